@@ sv/wrm_pkg.sv @@
// Package for the windowed rate meter: field widths, word types,
// controller/datapath command and status structs, and the controller state type.
// No dependencies.
package wrm_pkg;

  localparam int FRAME_W  = 17;   // window frame accumulator
  localparam int FIELD_W  = 16;   // frames field of an input word
  localparam int CLOCK_W  = 29;   // timer clock register
  localparam int STAMP_W  = 32;   // timer stamp and elapsed ticks
  localparam int RATE_W   = 32;   // measured rate
  localparam int PROD_W   = FRAME_W + CLOCK_W;
  localparam int DIV_STEPS = PROD_W;              // one quotient bit per cycle
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int ADDR_W   = 2;
  localparam int DATA_W   = 32;

  localparam int WINDOW_FRAMES_DEF = 32768;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] REG_TIMER_CLOCK = 2'd0;

  // Input word commands
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_ACCOUNT = 1'b1;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] frames;
    logic [STAMP_W-1:0] timer_stamp;
  } in_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] measured_hz;
    logic              updated;
  } out_word_t;

  typedef struct packed {
    logic load;      // take the input word, update the window
    logic mul_en;    // form frames * clock
    logic div_step;  // one restoring division step
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;  // the presented word closes a window with a valid measurement
    logic div_last;  // current division step is the final one
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

@@ sv/windowed_rate_meter.sv @@
// Windowed rate meter, top level: APB-style register port, controller and
// datapath. Depends on wrm_pkg, wrm_ctrl and wrm_dp.
//
// Usage:
// - Input channel (in_valid / in_stall / in_word): each word carries a command,
//   a frame count and a timer stamp. Restart opens a new window at the stamp;
//   account adds frames and closes the window once WINDOW_FRAMES is reached.
// - Output channel (out_valid / out_stall / out_word): exactly one word per
//   input word, with the held rate and a flag set when a new rate was measured.
// - Register port: timer_clock_hz at byte address 0, written with psel,
//   penable and pwrite high; pready is always high. Write it only while idle.
// - Sequence: a word that closes no window, or closes one with zero elapsed
//   ticks or zero clock, goes from acceptance to the output load state and
//   then into the output register. A word that yields a new measurement
//   passes the multiply state, the divide state (one quotient bit per cycle)
//   and the output load state before it reaches the output register.
// - Flow: one word at a time; in_stall is high while a word is in work. A
//   finished word waits in the output register while the next input word is
//   accepted; when out_stall holds that register, the next result waits
//   inside the block and in_stall stays high.
// - Reset (rst_n low, synchronous) clears the window, the held rate, the
//   clock register, the controller state and the output valid flag.
module windowed_rate_meter #(
  parameter int unsigned WINDOW_FRAMES = wrm_pkg::WINDOW_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wrm_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wrm_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wrm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wrm_pkg::DATA_W-1:0]  pwdata,
  output logic [wrm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [wrm_pkg::CLOCK_W-1:0] timer_clock_r;
  wrm_pkg::ctrl_cmd_t          cmd;
  wrm_pkg::dp_status_t         status;

  // Register port: write on the access cycle
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_clock_r <= '0;
    end else if (psel && penable && pwrite && (paddr == wrm_pkg::REG_TIMER_CLOCK)) begin
      timer_clock_r <= pwdata[wrm_pkg::CLOCK_W-1:0];
    end
  end

  // Read back the clock register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr == wrm_pkg::REG_TIMER_CLOCK) begin
      prdata = wrm_pkg::DATA_W'(timer_clock_r);
    end
  end

  wrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wrm_dp #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .timer_clock (timer_clock_r),
    .cmd         (cmd),
    .status      (status),
    .out_word    (out_word)
  );

endmodule

@@ sv/wrm_ctrl.sv @@
// Controller of the windowed rate meter: sequences accept, multiply, divide
// and output load. Depends on wrm_pkg.
module wrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wrm_pkg::dp_status_t status,
  output wrm_pkg::ctrl_cmd_t  cmd
);

  wrm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // Output register can take a new word when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != wrm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands from state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == wrm_pkg::ST_IDLE) && in_valid;
    cmd.mul_en   = (state_r == wrm_pkg::ST_MUL);
    cmd.div_step = (state_r == wrm_pkg::ST_DIV);
    cmd.out_load = (state_r == wrm_pkg::ST_DONE) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.need_div ? wrm_pkg::ST_MUL : wrm_pkg::ST_DONE;
        end
      end
      wrm_pkg::ST_MUL: state_nxt = wrm_pkg::ST_DIV;
      wrm_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = wrm_pkg::ST_DONE;
        end
      end
      wrm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = wrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wrm_pkg::ST_IDLE;
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A word that needs no division goes straight to the output stage
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !status.need_div) |=> (state_r == wrm_pkg::ST_DONE))
    else $error("word without division did not go to output stage");

  // The final division step always leads to the output stage
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> (state_r == wrm_pkg::ST_DONE))
    else $error("division did not finish into output stage");

  // A stalled result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled output word dropped");

endmodule

@@ sv/wrm_dp.sv @@
// Datapath of the windowed rate meter: window state, 17x29 multiplier,
// bit-serial restoring divider and output register. Depends on wrm_pkg.
module wrm_dp #(
  parameter int unsigned WINDOW_FRAMES = wrm_pkg::WINDOW_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wrm_pkg::in_word_t             in_word,
  input  logic [wrm_pkg::CLOCK_W-1:0]   timer_clock,
  input  wrm_pkg::ctrl_cmd_t            cmd,
  output wrm_pkg::dp_status_t           status,
  output wrm_pkg::out_word_t            out_word
);

  localparam logic [wrm_pkg::FRAME_W-1:0] WINDOW_LIMIT = wrm_pkg::FRAME_W'(WINDOW_FRAMES);

  logic [wrm_pkg::FRAME_W-1:0] frame_total_r;
  logic [wrm_pkg::STAMP_W-1:0] window_start_r;
  logic [wrm_pkg::RATE_W-1:0]  held_rate_r;
  logic                        updated_r;
  logic [wrm_pkg::FRAME_W-1:0] mul_frames_r;
  logic [wrm_pkg::STAMP_W-1:0] divisor_r;
  logic [wrm_pkg::PROD_W-1:0]  dividend_r;
  logic [wrm_pkg::STAMP_W-1:0] rem_r;
  logic [wrm_pkg::RATE_W-1:0]  quot_r;
  logic [wrm_pkg::CNT_W-1:0]   cnt_r;
  wrm_pkg::out_word_t          out_word_r;

  logic [wrm_pkg::FRAME_W-1:0] frame_sum;
  logic                        window_full;
  logic [wrm_pkg::STAMP_W-1:0] elapsed;
  logic [wrm_pkg::PROD_W-1:0]  product;
  logic [wrm_pkg::STAMP_W:0]   trial;
  logic [wrm_pkg::STAMP_W:0]   diff;
  logic                        q_bit;

  // Window bookkeeping for the presented word
  assign frame_sum   = frame_total_r + wrm_pkg::FRAME_W'(in_word.frames);
  assign window_full = (frame_sum >= WINDOW_LIMIT);
  assign elapsed     = in_word.timer_stamp - window_start_r;

  assign status.need_div = (in_word.command == wrm_pkg::CMD_ACCOUNT) && window_full &&
                           (elapsed != '0) && (timer_clock != '0);
  assign status.div_last = (cnt_r == wrm_pkg::CNT_W'(wrm_pkg::DIV_STEPS - 1));

  // Frames times clock, registered before division
  assign product = wrm_pkg::PROD_W'(mul_frames_r) * wrm_pkg::PROD_W'(timer_clock);

  // One restoring division step
  assign trial = {rem_r, dividend_r[wrm_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign q_bit = !diff[wrm_pkg::STAMP_W];

  assign out_word = out_word_r;

  // Window state and held rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r  <= '0;
      window_start_r <= '0;
      held_rate_r    <= '0;
      cnt_r          <= '0;
    end else begin
      if (cmd.load) begin
        if (in_word.command == wrm_pkg::CMD_RESTART) begin
          frame_total_r  <= '0;
          window_start_r <= in_word.timer_stamp;
        end else if (window_full) begin
          frame_total_r  <= '0;
          window_start_r <= in_word.timer_stamp;
        end else begin
          frame_total_r  <= frame_sum;
        end
      end
      if (cmd.mul_en) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
        if (status.div_last) begin
          held_rate_r <= {quot_r[wrm_pkg::RATE_W-2:0], q_bit};
        end
      end
    end
  end

  // Operands, divider shift registers and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mul_frames_r <= frame_sum;
      divisor_r    <= elapsed;
      updated_r    <= status.need_div;
    end
    if (cmd.mul_en) begin
      dividend_r <= product;
      rem_r      <= '0;
      quot_r     <= '0;
    end else if (cmd.div_step) begin
      dividend_r <= {dividend_r[wrm_pkg::PROD_W-2:0], 1'b0};
      rem_r      <= q_bit ? diff[wrm_pkg::STAMP_W-1:0] : trial[wrm_pkg::STAMP_W-1:0];
      quot_r     <= {quot_r[wrm_pkg::RATE_W-2:0], q_bit};
    end
    if (cmd.out_load) begin
      out_word_r.measured_hz <= held_rate_r;
      out_word_r.updated     <= updated_r;
    end
  end

  // Partial remainder stays below the divisor after every step
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < divisor_r))
    else $error("division remainder not below divisor");

endmodule

@@ bench/wrm_checker.sv @@
`timescale 1ns / 100ps
// Checker for the windowed rate meter: tracks the timer clock register and the
// window state, predicts one result word per accepted input word and compares
// the result words in order. Depends on wrm_pkg.
module wrm_checker #(
  parameter int unsigned WINDOW_FRAMES = wrm_pkg::WINDOW_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  wrm_pkg::in_word_t          in_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  wrm_pkg::out_word_t         out_word,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [wrm_pkg::ADDR_W-1:0] paddr,
  input  logic [wrm_pkg::DATA_W-1:0] pwdata,
  output int                         mismatch_count,
  output int                         pending_words
);

  // Shadow of the clock register and the measuring window
  logic [wrm_pkg::CLOCK_W-1:0] clock_hz;
  logic [wrm_pkg::FRAME_W-1:0] frame_total;
  logic [wrm_pkg::STAMP_W-1:0] window_start;
  logic [wrm_pkg::RATE_W-1:0]  held_rate;

  wrm_pkg::out_word_t rate_q[$];
  int                 fail_total;
  int                 result_no;

  // Advance the window by one event and return the result word it causes
  function automatic wrm_pkg::out_word_t measure_event(wrm_pkg::in_word_t w);
    wrm_pkg::out_word_t          r;
    logic [wrm_pkg::STAMP_W-1:0] elapsed;
    logic [63:0]                 product;
    r.updated = 1'b0;
    if (w.command == wrm_pkg::CMD_RESTART) begin
      frame_total  = '0;
      window_start = w.timer_stamp;
    end else begin
      frame_total = frame_total + wrm_pkg::FRAME_W'(w.frames);
      if (frame_total >= WINDOW_FRAMES) begin
        // elapsed ticks wrap modulo 2^32
        elapsed = w.timer_stamp - window_start;
        if (elapsed != '0 && clock_hz != '0) begin
          product   = 64'(frame_total) * 64'(clock_hz);
          held_rate = wrm_pkg::RATE_W'(product / 64'(elapsed));
          r.updated = 1'b1;
        end
        frame_total  = '0;
        window_start = w.timer_stamp;
      end
    end
    r.measured_hz = held_rate;
    return r;
  endfunction

  always @(posedge clk) begin
    wrm_pkg::out_word_t want;
    if (!rst_n) begin
      clock_hz     = '0;
      frame_total  = '0;
      window_start = '0;
      held_rate    = '0;
      rate_q.delete();
    end else begin
      // compare each delivered word with the oldest prediction
      if (out_valid && !out_stall) begin
        result_no++;
        if (rate_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result word %0d arrived with nothing expected: hz=%h upd=%b",
                     $realtime, result_no, out_word.measured_hz, out_word.updated);
        end else begin
          want = rate_q.pop_front();
          if (out_word.measured_hz !== want.measured_hz ||
              out_word.updated !== want.updated) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: result word %0d: expected hz=%h upd=%b, got hz=%h upd=%b",
                       $realtime, result_no, want.measured_hz, want.updated,
                       out_word.measured_hz, out_word.updated);
          end
        end
      end
      // track register writes
      if (psel && penable && pwrite && pready && paddr == wrm_pkg::REG_TIMER_CLOCK)
        clock_hz = pwdata[wrm_pkg::CLOCK_W-1:0];
      // predict for each accepted input word
      if (in_valid && !in_stall)
        rate_q.push_back(measure_event(in_word));
    end
    mismatch_count <= fail_total;
    pending_words  <= rate_q.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top for the windowed rate meter: clock, reset, input words,
// register writes and result-side stalls; the verdict comes from wrm_checker.
// Depends on wrm_pkg, windowed_rate_meter and wrm_checker.
module testbench;

  localparam int CYCLE_LIMIT = 1000000;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  wrm_pkg::in_word_t            in_word   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  wrm_pkg::out_word_t           out_word;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [wrm_pkg::ADDR_W-1:0]   paddr     = wrm_pkg::REG_TIMER_CLOCK;
  logic [wrm_pkg::DATA_W-1:0]   pwdata    = '0;
  logic [wrm_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  int                           mismatch_count;
  int                           pending_words;
  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  int                           phase_no      = 0;
  logic                         pressure_hold = 1'b0;
  int                           cycle_count   = 0;
  logic [wrm_pkg::STAMP_W-1:0]  timer_now     = '0;

  windowed_rate_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  wrm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls plus the long hold-off
  always @(posedge clk) begin
    out_stall <= pressure_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Hold off the result side for a long stretch while words keep coming
  initial begin
    wait (phase_no == 3);
    repeat (25) @(posedge clk);
    pressure_hold <= 1'b1;
    repeat (300) @(posedge clk);
    pressure_hold <= 1'b0;
  end

  function automatic wrm_pkg::in_word_t make_word(logic cmd,
                                                  logic [wrm_pkg::FIELD_W-1:0] frames,
                                                  logic [wrm_pkg::STAMP_W-1:0] stamp);
    wrm_pkg::in_word_t w;
    w.command     = cmd;
    w.frames      = frames;
    w.timer_stamp = stamp;
    return w;
  endfunction

  // Mostly account words on an advancing timer, with the odd restart and jump
  function automatic wrm_pkg::in_word_t random_word();
    wrm_pkg::in_word_t w;
    int unsigned       pick;
    w.command = ($urandom_range(99) < 8) ? wrm_pkg::CMD_RESTART : wrm_pkg::CMD_ACCOUNT;
    pick = $urandom_range(99);
    if (pick < 35)      w.frames = wrm_pkg::FIELD_W'($urandom_range(4095));
    else if (pick < 70) w.frames = wrm_pkg::FIELD_W'($urandom_range(32767, 8192));
    else                w.frames = wrm_pkg::FIELD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 5)       timer_now = timer_now;
    else if (pick < 35) timer_now = timer_now + $urandom_range(255, 1);
    else if (pick < 75) timer_now = timer_now + $urandom_range(1 << 20, 256);
    else                timer_now = timer_now + $urandom;
    w.timer_stamp = timer_now;
    return w;
  endfunction

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(wrm_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every result word has been delivered
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_clock(logic [wrm_pkg::DATA_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wrm_pkg::REG_TIMER_CLOCK;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_word(random_word());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clock still zero: restart ignores frames, window fills without a division
    send_word(make_word(wrm_pkg::CMD_RESTART, 16'hFFFF, 32'h0000_0000));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h0000, 32'h0000_0064));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'hFFFF, 32'h0000_00C8));

    // Timer wrap, zero elapsed ticks, exact window fill
    write_clock(32'd48000);
    send_word(make_word(wrm_pkg::CMD_RESTART, 16'h1234, 32'hFFFF_FF00));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h8000, 32'h0000_0100));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h9C40, 32'h0000_0100));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h7FFF, 32'h0000_03E8));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h0001, 32'hFFFF_FFFF));

    // Largest clock (upper write bits dropped), one tick elapsed: truncated rate
    write_clock(32'hFFFF_FFFF);
    send_word(make_word(wrm_pkg::CMD_RESTART, 16'h0000, 32'h0000_0005));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h7FFF, 32'h0000_0005));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'hFFFF, 32'h0000_0006));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h8000, 32'h8000_0005));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h5555, 32'hAAAA_AAAA));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'hAAAA, 32'h5555_5555));
    send_word(make_word(wrm_pkg::CMD_RESTART, 16'h0000, 32'hFFFF_FFFF));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h7FFF, 32'h0000_0000));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h0000, 32'h0000_1234));
    send_word(make_word(wrm_pkg::CMD_ACCOUNT, 16'h0001, 32'h1234_5678));

    // Sender idles a little, receiver a lot
    write_clock(32'd24576000);
    send_idle_pct <= 11;
    recv_idle_pct <= 61;
    phase_no      <= 1;
    run_random(500);

    // Sender idles a lot, receiver a little
    write_clock(32'd500000000);
    send_idle_pct <= 61;
    recv_idle_pct <= 11;
    phase_no      <= 2;
    run_random(500);

    // No idling; long result-side hold-off runs alongside
    write_clock(32'd1);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    phase_no      <= 3;
    run_random(260);
    write_clock(32'd0);
    run_random(100);
    write_clock(32'h3FFF_FFFF);
    run_random(260);

    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/wrm_pkg.sv
sv/wrm_ctrl.sv
sv/wrm_dp.sv
sv/windowed_rate_meter.sv
bench/wrm_checker.sv
bench/testbench.sv
